>>> src/ccr_pkg.sv
// Shared types, register indexes and fixed-point helpers for the circle wall collision core.
package ccr_pkg;

	localparam int CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] REG_WALL_LEFT        = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_WALL_BOTTOM      = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_WALL_RIGHT       = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_WALL_TOP         = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_WALL_RESTITUTION = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_WALL_FRICTION    = 3'd5;

	localparam logic [16:0] QONE = 17'd65536;
	localparam logic signed [31:0] S32MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32MIN = 32'sh8000_0000;

	// Divider shape: quotient bits, bits per pipeline stage, stage count
	localparam int DivBits  = 48;
	localparam int DivStep  = 4;
	localparam int DivStages = DivBits / DivStep;

	typedef struct packed {
		logic [15:0]        body_tag;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] spin;
		logic [30:0]        circle_radius;
		logic [30:0]        body_mass;
		logic [30:0]        inv_mass;
		logic [30:0]        inv_inertia;
		logic [16:0]        body_restitution;
		logic [16:0]        body_friction;
	} in_t;

	typedef struct packed {
		logic [15:0]        out_tag;
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic signed [31:0] new_spin;
	} out_t;

	// Saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = S32MAX;
		else if (v < -64'sd2147483648) r = S32MIN;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [63:0] sx(input logic signed [31:0] a);
		return {{32{a[31]}}, a};
	endfunction

	function automatic logic signed [31:0] zx31(input logic [30:0] a);
		return $signed({1'b0, a});
	endfunction

	// Q16.16 product, floor rounding, saturated
	function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		return sat32(p >>> 16);
	endfunction

	function automatic logic [16:0] capmin(input logic [16:0] a, input logic [16:0] b);
		logic [16:0] m;
		m = (a < b) ? a : b;
		return (m > QONE) ? QONE : m;
	endfunction

endpackage

>>> src/ccr_resolve.sv
// Pipelined impulse response with friction for one wall axis.
module ccr_resolve #(
	parameter bit AXIS_Y = 1'b0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic               in_act,
	input  ccr_pkg::in_t       in_body,
	input  logic [16:0]        wall_restitution,
	input  logic [16:0]        wall_friction,
	output logic               out_vld,
	output ccr_pkg::in_t       out_body
);

	localparam int DivFirst = 5;
	localparam int DivLast  = DivFirst + ccr_pkg::DivStages - 1;
	localparam int NStg     = DivLast + 3;

	typedef struct packed {
		logic               act;
		ccr_pkg::in_t       body;
		logic [16:0]        mu;
		logic signed [31:0] dv;
		logic signed [31:0] wr;
		logic signed [31:0] iir;
		logic signed [31:0] imp;
		logic signed [31:0] pt;
		logic signed [31:0] iirr;
		logic signed [31:0] num;
		logic signed [31:0] den;
		logic signed [31:0] absimp;
		logic signed [31:0] maxf;
		logic               neg;
		logic               dz;
		logic [ccr_pkg::DivBits-1:0] dq;
		logic [31:0]        rem;
		logic signed [31:0] j;
		logic signed [31:0] rj;
	} rs_t;

	rs_t        stg_s [1:NStg];
	rs_t        nx    [1:NStg];
	logic [NStg:1] vld_s;

	function automatic logic signed [31:0] get_vn(input ccr_pkg::in_t b);
		return AXIS_Y ? b.vel_y : b.vel_x;
	endfunction

	function automatic logic signed [31:0] get_vt(input ccr_pkg::in_t b);
		return AXIS_Y ? b.vel_x : b.vel_y;
	endfunction

	// Four restoring division steps
	function automatic rs_t div_step(input rs_t s);
		rs_t o;
		logic [32:0] t;
		o = s;
		for (int i = 0; i < ccr_pkg::DivStep; i++) begin
			t = {o.rem, o.dq[ccr_pkg::DivBits-1]};
			o.dq = {o.dq[ccr_pkg::DivBits-2:0], 1'b0};
			if (t >= {1'b0, o.den}) begin
				t = t - {1'b0, o.den};
				o.dq[0] = 1'b1;
			end
			o.rem = t[31:0];
		end
		return o;
	endfunction

	always_comb begin
		logic [16:0]        e;
		logic signed [31:0] fac;
		logic signed [31:0] qm;
		logic signed [31:0] jj;
		logic [31:0]        anum;
		rs_t                s;

		// Stage 1: normal impulse factor, spin and inertia products
		s = '0;
		s.act  = in_act;
		s.body = in_body;
		e      = ccr_pkg::capmin(in_body.body_restitution, wall_restitution);
		s.mu   = ccr_pkg::capmin(in_body.body_friction, wall_friction);
		fac    = 32'sd0 - (32'sd65536 + $signed({15'd0, e}));
		s.dv   = ccr_pkg::qmul(get_vn(in_body), fac);
		s.wr   = ccr_pkg::qmul(in_body.spin, ccr_pkg::zx31(in_body.circle_radius));
		s.iir  = ccr_pkg::qmul(ccr_pkg::zx31(in_body.inv_inertia),
			ccr_pkg::zx31(in_body.circle_radius));
		nx[1] = s;

		// Stage 2: impulse, reflected normal velocity, point velocity
		s = stg_s[1];
		s.imp  = ccr_pkg::qmul(s.dv, ccr_pkg::zx31(s.body.body_mass));
		s.pt   = ccr_pkg::sat32(ccr_pkg::sx(get_vt(s.body)) + ccr_pkg::sx(s.wr));
		s.iirr = ccr_pkg::qmul(s.iir, ccr_pkg::zx31(s.body.circle_radius));
		if (s.act) begin
			if (AXIS_Y) s.body.vel_y = ccr_pkg::sat32(ccr_pkg::sx(s.body.vel_y)
				+ ccr_pkg::sx(s.dv));
			else        s.body.vel_x = ccr_pkg::sat32(ccr_pkg::sx(s.body.vel_x)
				+ ccr_pkg::sx(s.dv));
		end
		nx[2] = s;

		// Stage 3: friction numerator, denominator, impulse magnitude
		s = stg_s[2];
		s.num = ccr_pkg::qmul(s.pt, $signed({15'd0, s.mu}));
		s.den = ccr_pkg::sat32(ccr_pkg::sx(ccr_pkg::zx31(s.body.inv_mass))
			+ ccr_pkg::sx(s.iirr));
		s.absimp = s.imp[31] ? ccr_pkg::sat32(64'sd0 - ccr_pkg::sx(s.imp)) : s.imp;
		nx[3] = s;

		// Stage 4: friction bound, load divider
		s = stg_s[3];
		s.maxf = ccr_pkg::qmul($signed({15'd0, s.mu}), s.absimp);
		s.neg  = s.num[31];
		s.dz   = (s.den <= 32'sd0);
		anum   = s.num[31] ? (32'd0 - s.num) : s.num;
		s.dq   = {anum, 16'd0};
		s.rem  = '0;
		nx[4] = s;

		// Divider stages
		for (int k = DivFirst; k <= DivLast; k++) begin
			nx[k] = div_step(stg_s[k-1]);
		end

		// Saturate quotient, zero numerator gives zero, set sign against sliding, clamp
		s = stg_s[DivLast];
		if (s.num == 32'sd0) qm = 32'sd0;
		else qm = (s.dz || (|s.dq[ccr_pkg::DivBits-1:31])) ? ccr_pkg::S32MAX
			: $signed({1'b0, s.dq[30:0]});
		jj = s.neg ? qm : (32'sd0 - qm);
		if (jj > s.maxf) jj = s.maxf;
		if (jj < (32'sd0 - s.maxf)) jj = 32'sd0 - s.maxf;
		s.j = jj;
		nx[DivLast+1] = s;

		// Tangential velocity update, lever product
		s = stg_s[DivLast+1];
		s.rj = ccr_pkg::qmul(ccr_pkg::zx31(s.body.circle_radius), s.j);
		if (s.act) begin
			if (AXIS_Y) s.body.vel_x = ccr_pkg::sat32(ccr_pkg::sx(s.body.vel_x)
				+ ccr_pkg::sx(ccr_pkg::qmul(s.j, ccr_pkg::zx31(s.body.inv_mass))));
			else        s.body.vel_y = ccr_pkg::sat32(ccr_pkg::sx(s.body.vel_y)
				+ ccr_pkg::sx(ccr_pkg::qmul(s.j, ccr_pkg::zx31(s.body.inv_mass))));
		end
		nx[DivLast+2] = s;

		// Spin update
		s = stg_s[DivLast+2];
		if (s.act) begin
			s.body.spin = ccr_pkg::sat32(ccr_pkg::sx(s.body.spin)
				+ ccr_pkg::sx(ccr_pkg::qmul(s.rj, ccr_pkg::zx31(s.body.inv_inertia))));
		end
		nx[NStg] = s;
	end

	// Advance payload
	always_ff @(posedge clk) begin
		for (int k = 1; k <= NStg; k++) stg_s[k] <= nx[k];
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[NStg-1:1], in_vld};
		end
	end

	assign out_vld  = vld_s[NStg];
	assign out_body = stg_s[NStg].body;

endmodule

>>> src/circle_wall_collision_response_core.sv
// Top level: wall registers, wall tests and two chained resolve pipelines.
// Throughput: one body per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the 12-stage friction quotient divider in each axis pipeline.
// Reset clears all valid bits and loads the wall registers with their defaults.
// The receiver cannot stall: each result is shown for exactly one cycle.
module circle_wall_collision_response_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  ccr_pkg::in_t                  body,
	output logic                          result_valid,
	output ccr_pkg::out_t                 result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ccr_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [31:0]                   cfg_data
);

	logic signed [31:0] wall_left_q, wall_bottom_q, wall_right_q, wall_top_q;
	logic [16:0]        wall_rest_q, wall_fric_q;

	logic         vld_s1, vld_s2, out_vld_q;
	logic         act_s1, act_s2;
	ccr_pkg::in_t body_s1, body_s2;
	logic         xo_vld, yo_vld;
	ccr_pkg::in_t xo_body, yo_body;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_left_q   <= '0;
			wall_bottom_q <= '0;
			wall_right_q  <= '0;
			wall_top_q    <= '0;
			wall_rest_q   <= ccr_pkg::QONE;
			wall_fric_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ccr_pkg::REG_WALL_LEFT:        wall_left_q   <= cfg_data;
				ccr_pkg::REG_WALL_BOTTOM:      wall_bottom_q <= cfg_data;
				ccr_pkg::REG_WALL_RIGHT:       wall_right_q  <= cfg_data;
				ccr_pkg::REG_WALL_TOP:         wall_top_q    <= cfg_data;
				ccr_pkg::REG_WALL_RESTITUTION: wall_rest_q   <= cfg_data[16:0];
				ccr_pkg::REG_WALL_FRICTION:    wall_fric_q   <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// Test one axis against its wall pair and clamp the position
	function automatic logic [32:0] wall_test(input logic signed [31:0] p,
			input logic signed [31:0] v, input logic [30:0] r,
			input logic signed [31:0] lo, input logic signed [31:0] hi);
		logic signed [63:0] rr;
		logic               act;
		logic signed [31:0] np;
		rr  = ccr_pkg::sx(ccr_pkg::zx31(r));
		act = 1'b0;
		np  = p;
		if (ccr_pkg::sx(p) - rr <= ccr_pkg::sx(lo)) begin
			if (v < 32'sd0) begin
				act = 1'b1;
				np  = ccr_pkg::sat32(ccr_pkg::sx(lo) + rr);
			end
		end else if (ccr_pkg::sx(p) + rr >= ccr_pkg::sx(hi)) begin
			if (v > 32'sd0) begin
				act = 1'b1;
				np  = ccr_pkg::sat32(ccr_pkg::sx(hi) - rr);
			end
		end
		return {act, np};
	endfunction

	// X wall stage
	always_ff @(posedge clk) begin
		logic [32:0]  t;
		ccr_pkg::in_t nb;
		t = wall_test(body.pos_x, body.vel_x, body.circle_radius,
			wall_left_q, wall_right_q);
		nb       = body;
		nb.pos_x = t[31:0];
		body_s1 <= nb;
		act_s1  <= t[32];
	end

	ccr_resolve #(.AXIS_Y(1'b0)) u_res_x (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_vld           (vld_s1),
		.in_act           (act_s1),
		.in_body          (body_s1),
		.wall_restitution (wall_rest_q),
		.wall_friction    (wall_fric_q),
		.out_vld          (xo_vld),
		.out_body         (xo_body)
	);

	// Y wall stage on the x-updated body
	always_ff @(posedge clk) begin
		logic [32:0]  t;
		ccr_pkg::in_t nb;
		t = wall_test(xo_body.pos_y, xo_body.vel_y, xo_body.circle_radius,
			wall_bottom_q, wall_top_q);
		nb       = xo_body;
		nb.pos_y = t[31:0];
		body_s2 <= nb;
		act_s2  <= t[32];
	end

	ccr_resolve #(.AXIS_Y(1'b1)) u_res_y (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_vld           (vld_s2),
		.in_act           (act_s2),
		.in_body          (body_s2),
		.wall_restitution (wall_rest_q),
		.wall_friction    (wall_fric_q),
		.out_vld          (yo_vld),
		.out_body         (yo_body)
	);

	// Register the result beat
	always_ff @(posedge clk) begin
		result.out_tag   <= yo_body.body_tag;
		result.new_pos_x <= yo_body.pos_x;
		result.new_pos_y <= yo_body.pos_y;
		result.new_vel_x <= yo_body.vel_x;
		result.new_vel_y <= yo_body.vel_y;
		result.new_spin  <= yo_body.spin;
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			vld_s1    <= start && !busy;
			vld_s2    <= xo_vld;
			out_vld_q <= yo_vld;
		end
	end

	assign result_valid = out_vld_q;

endmodule

>>> dv/circle_wall_collision_response_core_tb.sv
// Testbench for the circle wall collision core: queued body stimulus, in-order result checks.
`timescale 1ns / 100ps

module circle_wall_collision_response_core_tb;

	localparam int  CycleLimit = 400000;
	localparam int  DrainWait  = 50;
	localparam longint QOne    = 65536;
	localparam longint Max32   = 64'sd2147483647;
	localparam longint Min32   = -64'sd2147483648;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          start;
	logic          busy;
	ccr_pkg::in_t  body;
	logic          result_valid;
	ccr_pkg::out_t result;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [ccr_pkg::CfgIdxW-1:0] cfg_index;
	logic [31:0]   cfg_data;

	// mirror of the wall registers
	longint       box_left, box_bottom, box_right, box_top;
	logic [16:0]  box_restitution, box_friction;

	ccr_pkg::in_t  pending_bodies[$];
	ccr_pkg::out_t expected_bodies[$];
	int           gap_left;
	bit           idle_on;
	int           error_count;
	int           cycles;

	circle_wall_collision_response_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.body         (body),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	// Fixed-point arithmetic of the contact solver
	function automatic longint clip32(longint v);
		if (v > Max32) return Max32;
		if (v < Min32) return Min32;
		return v;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		longint p;
		p = a * b;
		return clip32(p >>> 16);
	endfunction

	function automatic longint fx_div(longint n, longint d);
		if (d <= 0) return (n > 0) ? Max32 : ((n < 0) ? Min32 : 0);
		return clip32((n * QOne) / d);
	endfunction

	function automatic longint coef_min(longint a, longint b);
		longint m;
		m = (a < b) ? a : b;
		return (m > QOne) ? QOne : m;
	endfunction

	// Reflect the normal velocity, then apply bounded friction impulse
	function automatic void bounce(inout longint vn, inout longint vt, inout longint w,
			input longint r, input ccr_pkg::in_t b);
		longint e, mu, dv, imp, pt, num, den, j, maxf, im, ii;
		im = b.inv_mass;
		ii = b.inv_inertia;
		e = coef_min(b.body_restitution, box_restitution);
		mu = coef_min(b.body_friction, box_friction);
		dv = fx_mul(vn, -(QOne + e));
		imp = fx_mul(dv, b.body_mass);
		vn = clip32(vn + dv);
		pt = clip32(vt + fx_mul(w, r));
		num = fx_mul(pt, mu);
		den = clip32(im + fx_mul(fx_mul(ii, r), r));
		j = clip32(-fx_div(num, den));
		maxf = fx_mul(mu, clip32(imp < 0 ? -imp : imp));
		if (j > maxf) j = maxf;
		if (j < -maxf) j = -maxf;
		vt = clip32(vt + fx_mul(j, im));
		w = clip32(w + fx_mul(fx_mul(r, j), ii));
	endfunction

	function automatic ccr_pkg::out_t resolve_body(ccr_pkg::in_t b);
		longint px, py, vx, vy, w, r;
		ccr_pkg::out_t o;
		px = b.pos_x; py = b.pos_y; vx = b.vel_x; vy = b.vel_y; w = b.spin;
		r = b.circle_radius;
		if (px - r <= box_left) begin
			if (vx < 0) begin
				px = clip32(box_left + r);
				bounce(vx, vy, w, r, b);
			end
		end else if (px + r >= box_right) begin
			if (vx > 0) begin
				px = clip32(box_right - r);
				bounce(vx, vy, w, r, b);
			end
		end
		if (py - r <= box_bottom) begin
			if (vy < 0) begin
				py = clip32(box_bottom + r);
				bounce(vy, vx, w, r, b);
			end
		end else if (py + r >= box_top) begin
			if (vy > 0) begin
				py = clip32(box_top - r);
				bounce(vy, vx, w, r, b);
			end
		end
		o.out_tag = b.body_tag;
		o.new_pos_x = px[31:0];
		o.new_pos_y = py[31:0];
		o.new_vel_x = vx[31:0];
		o.new_vel_y = vy[31:0];
		o.new_spin = w[31:0];
		return o;
	endfunction

	function automatic longint rand_s32();
		return longint'($signed($urandom()));
	endfunction

	function automatic longint rand_small(longint span);
		return longint'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic [16:0] rand_coef();
		if ($urandom_range(0, 9) == 0) return 17'($urandom_range(0, 17'h1FFFF));
		return 17'($urandom_range(0, 65536));
	endfunction

	// Coordinate placed near one of two walls or in between
	function automatic longint place(longint lo, longint hi, longint r);
		case ($urandom_range(0, 3))
			0: return lo + r + rand_small(32'h20000);
			1: return hi - r + rand_small(32'h20000);
			2: return lo + r;
			default: return (lo + hi) / 2 + rand_small(32'h80000);
		endcase
	endfunction

	function automatic ccr_pkg::in_t make_body();
		ccr_pkg::in_t b;
		longint r, px, py;
		b.body_tag = 16'($urandom());
		if ($urandom_range(0, 4) == 0) begin
			b.pos_x = $urandom(); b.pos_y = $urandom();
			b.vel_x = $urandom(); b.vel_y = $urandom(); b.spin = $urandom();
			b.circle_radius = 31'($urandom()); b.body_mass = 31'($urandom());
			b.inv_mass = 31'($urandom()); b.inv_inertia = 31'($urandom());
		end else begin
			r = ($urandom_range(0, 15) == 0) ? longint'($urandom_range(0, 32'h7FFFFFFF))
				: longint'($urandom_range(0, 32'h40000));
			px = place(box_left, box_right, r);
			py = place(box_bottom, box_top, r);
			b.pos_x = px[31:0]; b.pos_y = py[31:0];
			b.vel_x = 32'(($urandom_range(0, 9) == 0) ? rand_s32() : rand_small(32'h80000));
			b.vel_y = 32'(($urandom_range(0, 9) == 0) ? rand_s32() : rand_small(32'h80000));
			b.spin = 32'(($urandom_range(0, 9) == 0) ? rand_s32() : rand_small(32'h80000));
			b.circle_radius = r[30:0];
			b.body_mass = 31'($urandom_range(0, 32'h100000));
			b.inv_mass = ($urandom_range(0, 7) == 0) ? 31'd0 : 31'($urandom_range(0, 32'h40000));
			b.inv_inertia = ($urandom_range(0, 7) == 0) ? 31'd0
				: 31'($urandom_range(0, 32'h40000));
		end
		b.body_restitution = rand_coef();
		b.body_friction = rand_coef();
		return b;
	endfunction

	function automatic ccr_pkg::in_t plain_body(logic [15:0] tag, longint px, longint py,
			longint vx, longint vy, longint w, longint r);
		ccr_pkg::in_t b;
		b.body_tag = tag;
		b.pos_x = px[31:0]; b.pos_y = py[31:0];
		b.vel_x = vx[31:0]; b.vel_y = vy[31:0]; b.spin = w[31:0];
		b.circle_radius = r[30:0];
		b.body_mass = 31'(QOne); b.inv_mass = 31'(QOne); b.inv_inertia = 31'(QOne);
		b.body_restitution = 17'h8000; b.body_friction = 17'h8000;
		return b;
	endfunction

	// Write one register; valid stays high until the caller drops it
	task automatic write_reg(logic [ccr_pkg::CfgIdxW-1:0] idx, longint value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[31:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			ccr_pkg::REG_WALL_LEFT:        box_left = longint'($signed(value[31:0]));
			ccr_pkg::REG_WALL_BOTTOM:      box_bottom = longint'($signed(value[31:0]));
			ccr_pkg::REG_WALL_RIGHT:       box_right = longint'($signed(value[31:0]));
			ccr_pkg::REG_WALL_TOP:         box_top = longint'($signed(value[31:0]));
			ccr_pkg::REG_WALL_RESTITUTION: box_restitution = value[16:0];
			ccr_pkg::REG_WALL_FRICTION:    box_friction = value[16:0];
			default: ;
		endcase
	endtask

	task automatic set_box(longint l, longint bt, longint rt, longint tp,
			longint rest, longint fric);
		write_reg(ccr_pkg::REG_WALL_LEFT, l);
		write_reg(ccr_pkg::REG_WALL_BOTTOM, bt);
		write_reg(ccr_pkg::REG_WALL_RIGHT, rt);
		write_reg(ccr_pkg::REG_WALL_TOP, tp);
		write_reg(ccr_pkg::REG_WALL_RESTITUTION, rest);
		write_reg(ccr_pkg::REG_WALL_FRICTION, fric);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every queued body is accepted and every result is back
	task automatic drain();
		do @(negedge clk);
		while (pending_bodies.size() != 0 || start || expected_bodies.size() != 0);
		repeat (DrainWait) @(posedge clk);
	endtask

	task automatic queue_random(int count);
		repeat (count) pending_bodies.push_back(make_body());
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			error_count++;
		end
	endtask

	// Driver: predict on accept, then issue the next body or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) expected_bodies.push_back(resolve_body(body));
			if (!start || !busy) begin
				if (gap_left != 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (idle_on && $urandom_range(0, 9) == 0) begin
					gap_left = $urandom_range(0, 14);
					start <= 1'b0;
				end else if (pending_bodies.size() != 0) begin
					body <= pending_bodies.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each strobed result with the oldest prediction
	always @(posedge clk) begin
		ccr_pkg::out_t want;
		if (arst_n && result_valid) begin
			if (expected_bodies.size() == 0) begin
				$error("result with no body outstanding, tag %h", result.out_tag);
				error_count++;
			end else begin
				want = expected_bodies.pop_front();
				check_field("out_tag", 32'(want.out_tag), 32'(result.out_tag));
				check_field("new_pos_x", want.new_pos_x, result.new_pos_x);
				check_field("new_pos_y", want.new_pos_y, result.new_pos_y);
				check_field("new_vel_x", want.new_vel_x, result.new_vel_x);
				check_field("new_vel_y", want.new_vel_y, result.new_vel_y);
				check_field("new_spin", want.new_spin, result.new_spin);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		ccr_pkg::in_t b;
		arst_n = 1'b0;
		start = 1'b0;
		body = '0;
		cfg_valid = 1'b0;
		cfg_index = ccr_pkg::REG_WALL_LEFT;
		cfg_data = '0;
		gap_left = 0;
		idle_on = 1'b0;
		error_count = 0;
		cycles = 0;
		box_left = 0; box_bottom = 0; box_right = 0; box_top = 0;
		box_restitution = 17'(QOne); box_friction = 17'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset walls: everything sits on a degenerate box
		pending_bodies.push_back(plain_body(16'h0000, 0, 0, 0, 0, 0, 0));
		pending_bodies.push_back(plain_body(16'h0001, 0, 0, -32'h10000, 32'h10000, 32'h8000, 0));
		queue_random(20);
		drain();

		// Ordinary box of +/- 16
		set_box(-32'h100000, -32'h100000, 32'h100000, 32'h100000, 32'hC000, 32'h8000);
		// touching left wall exactly, moving out
		pending_bodies.push_back(plain_body(16'h0010, -32'h100000 + 32'h8000, 0,
			-32'h20000, 32'h10000, 32'h4000, 32'h8000));
		// right, bottom, top walls
		pending_bodies.push_back(plain_body(16'h0011, 32'h100000, 0, 32'h30000, 0, 0, 32'h10000));
		pending_bodies.push_back(plain_body(16'h0012, 0, -32'h100000, 32'h1000, -32'h30000,
			-32'h20000, 32'h10000));
		pending_bodies.push_back(plain_body(16'h0013, 0, 32'h0FF000, 32'h1000, 32'h30000,
			32'h20000, 32'h2000));
		// corner: both axes
		pending_bodies.push_back(plain_body(16'h0014, -32'h100000, -32'h100000, -32'h10000,
			-32'h10000, 32'h10000, 32'h10000));
		// at wall but moving inward
		pending_bodies.push_back(plain_body(16'h0015, -32'h100000, 32'h100000, 32'h10000,
			-32'h10000, 0, 32'h10000));
		// zero denominator in the friction quotient
		b = plain_body(16'h0016, -32'h100000, 0, -32'h40000, 32'h40000, 32'h10000, 32'h10000);
		b.inv_mass = '0; b.inv_inertia = '0;
		pending_bodies.push_back(b);
		// zero denominator with no sliding
		b = plain_body(16'h0018, -32'h100000, 0, -32'h40000, 0, 0, 32'h10000);
		b.inv_mass = '0; b.inv_inertia = '0;
		pending_bodies.push_back(b);
		// coefficients above one
		b = plain_body(16'h0017, 32'h100000, 32'h100000, 32'h40000, 32'h40000, -32'h30000, 32'h8000);
		b.body_restitution = 17'h1FFFF; b.body_friction = 17'h1FFFF;
		pending_bodies.push_back(b);
		// field extremes
		b = plain_body(16'hFFFF, Max32, Max32, Max32, Max32, Max32, Max32);
		b.body_mass = '1; b.inv_mass = '1; b.inv_inertia = '1;
		b.body_restitution = 17'(QOne); b.body_friction = 17'(QOne);
		pending_bodies.push_back(b);
		b = plain_body(16'h8000, Min32, Min32, Min32, Min32, Min32, 0);
		b.body_mass = '1; b.body_restitution = '0; b.body_friction = '0;
		pending_bodies.push_back(b);
		idle_on = 1'b1;
		queue_random(500);
		drain();

		// Extreme walls, no restitution, full friction
		set_box(Min32, Min32, Max32, Max32, 0, QOne);
		queue_random(300);
		drain();

		// Inverted box near the limits; clamp saturates, coefficients over one
		set_box(32'sh7FFF0000, 32'sh7FFF0000, -32'sh7FFF0000, -32'sh7FFF0000, 32'h1FFFF, 32'h1FFFF);
		pending_bodies.push_back(plain_body(16'h0020, 0, 0, -32'h10000, 32'h10000,
			32'h10000, 32'h7FFFFFFF));
		pending_bodies.push_back(plain_body(16'h0021, 0, 0, 32'h10000, -32'h10000,
			-32'h10000, 32'h40000000));
		queue_random(400);
		drain();

		// Random box, no idling at the end
		set_box(-longint'($urandom_range(32'h10000, 32'h400000)),
			-longint'($urandom_range(32'h10000, 32'h400000)),
			longint'($urandom_range(32'h10000, 32'h400000)),
			longint'($urandom_range(32'h10000, 32'h400000)),
			$urandom_range(0, 65536), $urandom_range(0, 65536));
		queue_random(300);
		drain();
		idle_on = 1'b0;
		queue_random(360);
		drain();

		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
src/ccr_pkg.sv
src/ccr_resolve.sv
src/circle_wall_collision_response_core.sv
dv/circle_wall_collision_response_core_tb.sv
